// ----- sv/mbrc_pkg.sv -----
// Shared types, constants and the bytewise CRC-16/MODBUS update for the
// Modbus RTU response checker. No dependencies.
package mbrc_pkg;

  localparam int unsigned MAX_FRAME_DEF = 256;
  localparam int unsigned MIN_FRAME     = 4;
  localparam int unsigned LEN_W         = 9;
  localparam int unsigned TDATA_OUT_W   = 32;
  localparam int unsigned TDATA_IN_W    = 8;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FC_READ_COILS    = 8'h01;
  localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
  localparam logic [7:0] FC_WRITE_SINGLE  = 8'h06;

  localparam logic [7:0] FIRST_ADDR_RST  = 8'd1;
  localparam logic [7:0] SECOND_ADDR_RST = 8'd2;

  // Register index, taken from the word address on the configuration port.
  localparam logic REG_FIRST_ADDR  = 1'b0;
  localparam logic REG_SECOND_ADDR = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_ADDRESS  = 3'd1,
    ST_BAD_FUNCTION = 3'd2,
    ST_CRC_MISMATCH = 3'd3,
    ST_TOO_SHORT    = 3'd4,
    ST_TOO_LONG     = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] first_addr;
    logic [7:0] second_addr;
  } cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0] frame_length;
    logic [7:0]       function_code;
    logic [7:0]       slave_address;
    status_e          status;
  } result_t;

  // One byte through the reflected CRC-16, one bit per step.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic func_ok(input logic [7:0] f);
    return (f == FC_READ_COILS) || (f == FC_READ_HOLDING) || (f == FC_WRITE_SINGLE);
  endfunction

endpackage

// ----- sv/modbus_rtu_response_checker.sv -----
// Modbus RTU response checker, top level: input register, frame unit,
// result register and configuration port. Depends on mbrc_pkg, mbrc_regs and
// mbrc_frame.
// A status result is registered in the result register when the last byte of a
// frame leaves the input register, and is transferred out from there.
// Throughput: one byte per cycle, set by the bytewise CRC update; only a last
// byte waits in the input register, and only while an earlier result is held.
// Reset (rst_ni, asynchronous, active low) restores addresses 1 and 2,
// the CRC to 0xFFFF, clears all frame state and empties both registers.
module modbus_rtu_response_checker import mbrc_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Received byte stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic                   s_axis_tlast,   // last byte of the frame
  // Status results, one per frame.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [2:0] status, [10:3] slave_address, [18:11] function_code,
  // [27:19] frame_length, [31:28] zero
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,
  // Configuration port.
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned PAD_W = TDATA_OUT_W - LEN_W - 8 - 8 - 3;

  cfg_t       cfg;
  result_t    result;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q, in_byte_d;
  logic       in_last_q, in_last_d;
  logic       out_valid_q, out_valid_d;
  result_t    res_q, res_d;
  logic       out_free;
  logic       advance;

  // The result register is free when empty or being drained this cycle.
  // Ordinary bytes always move on; only a last byte waits for a free slot.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || advance;

  mbrc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mbrc_frame #(
    .MAX_FRAME (MAX_FRAME)
  ) u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  // Input register.
  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    in_last_d  = in_last_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
      in_byte_d  = s_axis_tdata[7:0];
      in_last_d  = s_axis_tlast;
    end
  end

  // Result register: loaded when a last byte is processed.
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    res_d       = res_q;
    if (advance && in_last_q) begin
      out_valid_d = 1'b1;
      res_d       = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    in_last_q <= in_last_d;
    res_q     <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, res_q.frame_length, res_q.function_code,
                          res_q.slave_address, res_q.status};

  // A byte that does not end a frame never waits in the input register.
  a_mid_byte_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !in_last_q |-> advance)
    else $error("non-final byte stalled in input register");

  // A processed last byte produces a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> out_valid_q)
    else $error("last byte processed without a result");

  // A held result is never overwritten by the next frame's last byte.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready && in_valid_q && in_last_q |-> !advance)
    else $error("pending result overwritten");

  // A short-frame status always carries a length under the minimum.
  a_short_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.status == ST_TOO_SHORT |-> res_q.frame_length < LEN_W'(MIN_FRAME))
    else $error("short status with a long frame length");

endmodule

// ----- sv/mbrc_regs.sv -----
// Configuration registers of the Modbus RTU response checker on an APB-style
// port. Depends on mbrc_pkg.
module mbrc_regs import mbrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        REG_FIRST_ADDR:  cfg_d.first_addr  = pwdata[7:0];
        REG_SECOND_ADDR: cfg_d.second_addr = pwdata[7:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_addr  <= FIRST_ADDR_RST;
      cfg_q.second_addr <= SECOND_ADDR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FIRST_ADDR:  prdata = {24'd0, cfg_q.first_addr};
      REG_SECOND_ADDR: prdata = {24'd0, cfg_q.second_addr};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/mbrc_frame.sv -----
// Per-frame state of the Modbus RTU response checker: running CRC, two-byte
// hold line, byte count and header bytes, plus the status decision.
// Depends on mbrc_pkg.
module mbrc_frame import mbrc_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  cfg_t       cfg_i,
  output result_t    result_o
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);

  logic [15:0]      crc_q, crc_d;
  logic [7:0]       older_q, older_d;
  logic [7:0]       newer_q, newer_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       addr_q, addr_d;
  logic [7:0]       func_q, func_d;
  logic             ovf_q, ovf_d;

  logic [15:0]      crc_n;
  logic [CNT_W-1:0] cnt_n;
  logic [7:0]       addr_n, func_n;
  logic             ovf_n;
  status_e          status;

  // State after this byte, before any end-of-frame clear.
  always_comb begin
    crc_n  = crc_q;
    addr_n = addr_q;
    func_n = func_q;
    cnt_n  = cnt_q;
    ovf_n  = ovf_q;
    if (cnt_q >= CNT_W'(2) || ovf_q) begin
      crc_n = crc_byte(crc_q, older_q);
    end
    if (!ovf_q && cnt_q == CNT_W'(0)) begin
      addr_n = byte_i;
    end else if (!ovf_q && cnt_q == CNT_W'(1)) begin
      func_n = byte_i;
    end
    if (cnt_q < CNT_W'(MAX_FRAME)) begin
      cnt_n = cnt_q + CNT_W'(1);
    end else begin
      ovf_n = 1'b1;
    end
  end

  // First failing check decides; the length checks come first.
  always_comb begin
    if (cnt_n < CNT_W'(MIN_FRAME) && !ovf_n) begin
      status = ST_TOO_SHORT;
    end else if (ovf_n) begin
      status = ST_TOO_LONG;
    end else if (addr_n != cfg_i.first_addr && addr_n != cfg_i.second_addr) begin
      status = ST_BAD_ADDRESS;
    end else if (!func_ok(func_n)) begin
      status = ST_BAD_FUNCTION;
    end else if (newer_q != crc_n[7:0] || byte_i != crc_n[15:8]) begin
      status = ST_CRC_MISMATCH;
    end else begin
      status = ST_OK;
    end
  end

  assign result_o.status        = status;
  assign result_o.slave_address = addr_n;
  assign result_o.function_code = func_n;
  assign result_o.frame_length  = LEN_W'(cnt_n);

  always_comb begin
    crc_d   = crc_q;
    older_d = older_q;
    newer_d = newer_q;
    cnt_d   = cnt_q;
    addr_d  = addr_q;
    func_d  = func_q;
    ovf_d   = ovf_q;
    if (advance_i) begin
      if (last_i) begin
        crc_d   = CRC_INIT;
        older_d = '0;
        newer_d = '0;
        cnt_d   = '0;
        addr_d  = '0;
        func_d  = '0;
        ovf_d   = 1'b0;
      end else begin
        crc_d   = crc_n;
        older_d = newer_q;
        newer_d = byte_i;
        cnt_d   = cnt_n;
        addr_d  = addr_n;
        func_d  = func_n;
        ovf_d   = ovf_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CRC_INIT;
      older_q <= '0;
      newer_q <= '0;
      cnt_q   <= '0;
      addr_q  <= '0;
      func_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      crc_q   <= crc_d;
      older_q <= older_d;
      newer_q <= newer_d;
      cnt_q   <= cnt_d;
      addr_q  <= addr_d;
      func_q  <= func_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the Modbus RTU response checker: drives framed
// bytes on the input stream, predicts one status report per frame, and checks
// the output stream. Depends on mbrc_pkg and modbus_rtu_response_checker.
`timescale 1ns / 1ps

module tb;
  import mbrc_pkg::*;

  // A result passes the input and result registers; the settle wait is padded.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLDOFF_LEN   = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } rx_beat_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] rx_byte
  logic        s_axis_tlast  = 1'b0;   // last byte of the frame
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [2:0] status, [10:3] slave_address, [18:11] function_code,
  // [27:19] frame_length, [31:28] zero
  logic [31:0] m_axis_tdata;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = 3'd0;
  logic [31:0] pwdata  = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  modbus_rtu_response_checker u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk_i = ~clk_i;

  // Bytes waiting to be offered, and the status reports still owed by the DUT.
  rx_beat_t    rx_pending[$];
  result_t     frame_reports[$];
  logic [7:0]  frame_buf[$];
  int unsigned queued_bytes;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  logic        in_xfer        = 1'b0;

  // Long receiver hold-off, armed once by the stimulus and counted down here.
  logic        holdoff_arm  = 1'b0;
  logic        holdoff_used = 1'b0;
  int unsigned holdoff_left = 0;

  // Predictor copy of the address registers and of the per-frame state.
  cfg_t        cfg_q     = '{first_addr: FIRST_ADDR_RST, second_addr: SECOND_ADDR_RST};
  logic [15:0] crc_acc   = CRC_INIT;
  logic [7:0]  held_old  = 8'h00;
  logic [7:0]  held_new  = 8'h00;
  logic [8:0]  seen_cnt  = 9'd0;
  logic [7:0]  addr_b    = 8'h00;
  logic [7:0]  func_b    = 8'h00;
  logic        ovf       = 1'b0;

  // Reflected CRC-16 with polynomial 0xA001, one byte at a time.
  function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // Advance the frame tracker by one accepted byte. The last two bytes of a
  // frame stay in a two-deep delay line so they never enter the CRC, and on
  // the last byte the checks run in order: length, address, function, CRC.
  task automatic track_rx_byte(input logic [7:0] b, input logic is_last);
    result_t rep;
    if (seen_cnt >= 9'd2 || ovf) crc_acc = crc16_fold(crc_acc, held_old);
    held_old = held_new;
    held_new = b;
    if (!ovf && seen_cnt == 9'd0) addr_b = b;
    else if (!ovf && seen_cnt == 9'd1) func_b = b;
    // The count saturates at the frame cap; one more byte marks overflow.
    if (seen_cnt < MAX_FRAME_DEF) seen_cnt = seen_cnt + 9'd1;
    else ovf = 1'b1;
    if (is_last) begin
      if (seen_cnt < MIN_FRAME && !ovf) rep.status = ST_TOO_SHORT;
      else if (ovf) rep.status = ST_TOO_LONG;
      else if (addr_b != cfg_q.first_addr && addr_b != cfg_q.second_addr)
        rep.status = ST_BAD_ADDRESS;
      else if (func_b != FC_READ_COILS && func_b != FC_READ_HOLDING &&
               func_b != FC_WRITE_SINGLE)
        rep.status = ST_BAD_FUNCTION;
      else if (held_old != crc_acc[7:0] || held_new != crc_acc[15:8])
        rep.status = ST_CRC_MISMATCH;
      else rep.status = ST_OK;
      rep.slave_address = addr_b;
      rep.function_code = func_b;
      rep.frame_length  = seen_cnt;
      frame_reports.push_back(rep);
      crc_acc  = CRC_INIT;
      held_old = 8'h00;
      held_new = 8'h00;
      seen_cnt = 9'd0;
      addr_b   = 8'h00;
      func_b   = 8'h00;
      ovf      = 1'b0;
    end
  endtask

  // Sender: a byte that has been offered stays on the bus until its transfer;
  // otherwise the next byte is offered unless this cycle is chosen as a gap.
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_xfer) begin
      if (rst_ni && rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_pending[0].data;
        s_axis_tlast  <= rx_pending[0].is_last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (holdoff_arm && !holdoff_used) begin
      holdoff_left <= HOLDOFF_LEN;
      holdoff_used <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // Receiver: stalls at random, and without a break during the hold-off.
  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && holdoff_left == 0 && $urandom_range(99) >= recv_stall_pct;
  end

  // Monitor: every input transfer feeds the predictor, every output transfer
  // is compared with the oldest report still owed.
  always @(posedge clk_i) begin
    result_t exp_rep;
    in_xfer <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        void'(rx_pending.pop_front());
        track_rx_byte(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (frame_reports.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected report, expected none, got %08h", $time, m_axis_tdata);
        end else begin
          exp_rep = frame_reports.pop_front();
          if (m_axis_tdata[2:0] !== exp_rep.status ||
              m_axis_tdata[10:3] !== exp_rep.slave_address ||
              m_axis_tdata[18:11] !== exp_rep.function_code ||
              m_axis_tdata[27:19] !== exp_rep.frame_length) begin
            mismatches++;
            $display("%0t: report mismatch, expected status %0d addr %02h func %02h len %0d",
                     $time, exp_rep.status, exp_rep.slave_address,
                     exp_rep.function_code, exp_rep.frame_length);
            $display("%0t:                  actual status %0d addr %02h func %02h len %0d",
                     $time, m_axis_tdata[2:0], m_axis_tdata[10:3],
                     m_axis_tdata[18:11], m_axis_tdata[27:19]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** modbus_rtu_response_checker: FAILED **");
      $finish;
    end
  end

  // Two-phase register write; upper data bits carry noise the block ignores.
  task automatic cfg_write(input logic reg_idx, input logic [7:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= ($urandom() & 32'hFFFF_FF00) | {24'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_idx == REG_FIRST_ADDR) cfg_q.first_addr = val;
    else cfg_q.second_addr = val;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic append_crc();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_buf[k]) c = crc16_fold(c, frame_buf[k]);
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
  endtask

  task automatic commit_frame();
    foreach (frame_buf[k])
      rx_pending.push_back('{data: frame_buf[k], is_last: (k == frame_buf.size() - 1)});
    queued_bytes += frame_buf.size();
    frame_buf.delete();
  endtask

  // Mostly well-formed responses with random payload; the rest carry a wrong
  // address, a wrong function, a damaged CRC, too few bytes or plain noise.
  task automatic make_random_frame();
    int unsigned pick;
    int unsigned idx;
    logic [7:0]  a;
    logic [7:0]  f;
    pick = $urandom_range(99);
    if (pick >= 88) begin
      repeat (pick >= 94 ? $urandom_range(3, 1) : $urandom_range(12, 4))
        frame_buf.push_back(8'($urandom()));
    end else begin
      a = $urandom_range(1) ? cfg_q.first_addr : cfg_q.second_addr;
      case ($urandom_range(2))
        0: f = FC_READ_COILS;
        1: f = FC_READ_HOLDING;
        default: f = FC_WRITE_SINGLE;
      endcase
      if (pick >= 60 && pick < 68)
        do a = 8'($urandom()); while (a == cfg_q.first_addr || a == cfg_q.second_addr);
      if (pick >= 68 && pick < 76)
        do f = 8'($urandom());
        while (f == FC_READ_COILS || f == FC_READ_HOLDING || f == FC_WRITE_SINGLE);
      frame_buf.push_back(a);
      frame_buf.push_back(f);
      repeat ($urandom_range(10)) frame_buf.push_back(8'($urandom()));
      append_crc();
      if (pick >= 76) begin
        idx = frame_buf.size() - 1 - $urandom_range(1);
        frame_buf[idx] = frame_buf[idx] ^ 8'(1 << $urandom_range(7));
      end
    end
    commit_frame();
  endtask

  // Wait until every byte went in and every report came out, then let the
  // pipeline settle so the next register write sees an idle block.
  task automatic drain();
    while (rx_pending.size() != 0 || frame_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [7:0] a0, input logic [7:0] a1,
                           input int unsigned idle, input int unsigned stall,
                           input int unsigned nbytes, input bit with_long);
    cfg_write(REG_FIRST_ADDR, a0);
    cfg_write(REG_SECOND_ADDR, a1);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    queued_bytes   = 0;
    if (with_long) begin
      // A valid frame exactly at the cap, then one that runs past it.
      frame_buf.push_back(cfg_q.first_addr);
      frame_buf.push_back(FC_READ_HOLDING);
      repeat (MAX_FRAME_DEF - 4) frame_buf.push_back(8'($urandom()));
      append_crc();
      commit_frame();
      repeat ($urandom_range(MAX_FRAME_DEF + 8, MAX_FRAME_DEF + 1))
        frame_buf.push_back(8'($urandom()));
      commit_frame();
    end
    while (queued_bytes < nbytes) make_random_frame();
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames against the reset addresses 1 and 2.
    frame_buf = '{FIRST_ADDR_RST, FC_READ_HOLDING};      // minimal good frame
    append_crc();
    commit_frame();
    frame_buf = '{8'hFF};                                // single byte, too short
    commit_frame();
    frame_buf = '{SECOND_ADDR_RST, FC_WRITE_SINGLE, 8'h00};  // three bytes, too short
    commit_frame();
    frame_buf = '{8'h00, FC_READ_COILS};                 // unknown slave
    append_crc();
    commit_frame();
    frame_buf = '{SECOND_ADDR_RST, 8'hFF};               // unsupported function
    append_crc();
    commit_frame();
    frame_buf = '{SECOND_ADDR_RST, FC_WRITE_SINGLE, 8'h00};  // good, function 6
    append_crc();
    commit_frame();
    frame_buf = '{FIRST_ADDR_RST, FC_READ_COILS, 8'h80};  // CRC high byte damaged
    append_crc();
    frame_buf[4] = frame_buf[4] ^ 8'h80;
    commit_frame();
    drain();

    run_phase(8'h00, 8'hFF, 0, 0, 200, 1'b1);
    run_phase(8'hFF, 8'h00, 87, 0, 200, 1'b0);
    run_phase(8'($urandom()), 8'($urandom()), 0, 87, 200, 1'b0);
    run_phase(8'h5A, 8'h5A, 16, 16, 200, 1'b0);

    // Receiver holds off for a long stretch while bytes keep coming, so the
    // output backs up and the input stream has to stall.
    holdoff_arm = 1'b1;
    run_phase(FIRST_ADDR_RST, SECOND_ADDR_RST, 0, 0, 150, 1'b0);

    if (mismatches == 0) begin
      $display("** modbus_rtu_response_checker: PASSED **");
    end else begin
      $display("** modbus_rtu_response_checker: FAILED **");
    end
    $finish;
  end

endmodule

// ----- modbus_rtu_response_checker.f -----
sv/mbrc_pkg.sv
sv/mbrc_regs.sv
sv/mbrc_frame.sv
sv/modbus_rtu_response_checker.sv
tb/sv/tb.sv
